// ===== sv/cmav_pkg.sv =====
// Shared constants, payload types and helpers of the clamped moving average block.
package cmav_pkg;

  // Window length in frames; a power of two so the mean is a plain shift.
  localparam int unsigned WindowDepth  = 8;
  localparam int unsigned ChannelCount = 6;
  localparam int unsigned SampleBits   = 12;
  localparam int unsigned WinBits      = $clog2(WindowDepth);
  localparam int unsigned SumBits      = SampleBits + WinBits;

  // Configuration port
  localparam int unsigned NumCeilRegs  = 6;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 12;

  typedef logic [SampleBits-1:0]          sample_t;
  typedef sample_t [ChannelCount-1:0]     frame_t;
  typedef logic [SumBits-1:0]             sum_t;
  typedef sum_t [ChannelCount-1:0]        sums_t;
  typedef sample_t [NumCeilRegs-1:0]      ceil_regs_t;

  localparam sample_t UpperReset = '1;
  localparam sample_t LowerReset = SampleBits'(2);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_UPPER_CH0   = 3'd0,
    CFG_UPPER_CH1   = 3'd1,
    CFG_UPPER_CH2   = 3'd2,
    CFG_UPPER_CH3   = 3'd3,
    CFG_UPPER_CH4   = 3'd4,
    CFG_UPPER_CH5   = 3'd5,
    CFG_LOWER_LIMIT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
    sample_t sample_ch3;
    sample_t sample_ch4;
    sample_t sample_ch5;
  } in_beat_t;

  typedef struct packed {
    sample_t raw_mean_ch0;
    sample_t raw_mean_ch1;
    sample_t raw_mean_ch2;
    sample_t raw_mean_ch3;
    sample_t raw_mean_ch4;
    sample_t raw_mean_ch5;
    sample_t clamped_mean_ch0;
    sample_t clamped_mean_ch1;
    sample_t clamped_mean_ch2;
    sample_t clamped_mean_ch3;
    sample_t clamped_mean_ch4;
    sample_t clamped_mean_ch5;
  } out_beat_t;

  // Input beat to a channel-indexed frame
  function automatic frame_t unpack_in(in_beat_t b);
    frame_t f;
    f[0] = b.sample_ch0;
    f[1] = b.sample_ch1;
    f[2] = b.sample_ch2;
    f[3] = b.sample_ch3;
    f[4] = b.sample_ch4;
    f[5] = b.sample_ch5;
    return f;
  endfunction

  // Channel-indexed means to an output beat
  function automatic out_beat_t pack_out(frame_t r, frame_t c);
    out_beat_t b;
    b.raw_mean_ch0     = r[0];
    b.raw_mean_ch1     = r[1];
    b.raw_mean_ch2     = r[2];
    b.raw_mean_ch3     = r[3];
    b.raw_mean_ch4     = r[4];
    b.raw_mean_ch5     = r[5];
    b.clamped_mean_ch0 = c[0];
    b.clamped_mean_ch1 = c[1];
    b.clamped_mean_ch2 = c[2];
    b.clamped_mean_ch3 = c[3];
    b.clamped_mean_ch4 = c[4];
    b.clamped_mean_ch5 = c[5];
    return b;
  endfunction

endpackage

// ===== sv/cmav_cell.sv =====
// One window slot: holds a raw and a clamped frame and passes them on when the window shifts.
module cmav_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  cmav_pkg::frame_t raw_i,
  input  cmav_pkg::frame_t clamp_i,
  output cmav_pkg::frame_t raw_o,
  output cmav_pkg::frame_t clamp_o
);
  import cmav_pkg::*;

  frame_t raw_q, raw_d;
  frame_t clamp_q, clamp_d;

  // Take the neighbor's frame on each shift
  always_comb begin
    raw_d   = shift_i ? raw_i   : raw_q;
    clamp_d = shift_i ? clamp_i : clamp_q;
  end

  // History starts at zero so the warm-up frames average against zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q   <= '0;
      clamp_q <= '0;
    end else begin
      raw_q   <= raw_d;
      clamp_q <= clamp_d;
    end
  end

  assign raw_o   = raw_q;
  assign clamp_o = clamp_q;

endmodule

// ===== sv/cmav_sum.sv =====
// Running window sums per channel: add the newest frame, drop the one leaving the window.
module cmav_sum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cmav_pkg::frame_t new_i,
  input  cmav_pkg::frame_t old_i,
  output cmav_pkg::sums_t  sum_d_o,
  output cmav_pkg::sums_t  sum_o
);
  import cmav_pkg::*;

  sums_t sum_q, sum_d;

  // sum - oldest + newest; never goes negative since the oldest is part of the sum
  always_comb begin
    for (int ch = 0; ch < ChannelCount; ch++) begin
      sum_d[ch] = load_i ? (sum_q[ch] - SumBits'(old_i[ch]) + SumBits'(new_i[ch]))
                         : sum_q[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_d_o = sum_d;
  assign sum_o   = sum_q;

endmodule

// ===== sv/clamped_moving_average_6ch_unit.sv =====
// Top level: six-channel clamp and eight-frame moving average over a chain of window cells.
//
//   port group   dir  handshake                 payload
//   in           in   in_valid_i / in_stall_o    in_beat_i  (six 12-bit samples)
//   out          out  out_valid_o / out_stall_i  out_beat_o (six raw, six clamped means)
//   cfg          in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One frame per cycle while the output is not stalled; each result appears in the cycle after its frame is taken.
// The window is a chain of WindowDepth cells that shift on every accepted frame;
// the last cell feeds the running-sum subtract, so the rate is set by the
// clamp, add and subtract path into the sum and output registers.
// Reset clears history, sums and the output valid, and loads the limit defaults.
// While a result is stalled the input stalls too; the next frame is taken in the cycle it leaves.
module clamped_moving_average_6ch_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cmav_pkg::in_beat_t                  in_beat_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cmav_pkg::out_beat_t                 out_beat_o,
  input  logic                                cfg_we_i,
  input  logic [cmav_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [cmav_pkg::CfgDataBits-1:0]    cfg_data_i
);
  import cmav_pkg::*;

  ceil_regs_t upper_q, upper_d;
  sample_t    lower_q, lower_d;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_beat_q, out_beat_d;

  logic   accept;
  frame_t raw_in, clamp_in, ceil;
  frame_t raw_mean, clamp_mean;
  sums_t  raw_sum_d, raw_sum_q, clamp_sum_d, clamp_sum_q;

  frame_t chain_raw   [WindowDepth+1];
  frame_t chain_clamp [WindowDepth+1];

  // Handshake: the output register frees up when its beat is taken
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  // Limit registers
  always_comb begin
    upper_d = upper_q;
    lower_d = lower_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LOWER_LIMIT) begin
        lower_d = cfg_data_i[SampleBits-1:0];
      end
      for (int r = 0; r < NumCeilRegs; r++) begin
        if (cfg_idx_i == CfgIdxBits'(CFG_UPPER_CH0 + r)) begin
          upper_d[r] = cfg_data_i[SampleBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= {NumCeilRegs{UpperReset}};
      lower_q <= LowerReset;
    end else begin
      upper_q <= upper_d;
      lower_q <= lower_d;
    end
  end

  // Per-channel ceiling; channels beyond the registers have none
  for (genvar ch = 0; ch < ChannelCount; ch++) begin : g_ceil
    if (ch < NumCeilRegs) begin : g_reg
      assign ceil[ch] = upper_q[ch];
    end else begin : g_open
      assign ceil[ch] = '1;
    end
  end

  // Clamp: ceiling first, then floor, so the floor wins when they cross
  always_comb begin
    sample_t c;
    raw_in = unpack_in(in_beat_i);
    for (int ch = 0; ch < ChannelCount; ch++) begin
      c = (raw_in[ch] >= ceil[ch]) ? ceil[ch] : raw_in[ch];
      clamp_in[ch] = (c <= lower_q) ? lower_q : c;
    end
  end

  // Window: a row of cells, newest at the head
  assign chain_raw[0]   = raw_in;
  assign chain_clamp[0] = clamp_in;

  for (genvar s = 0; s < WindowDepth; s++) begin : g_cell
    cmav_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .raw_i   (chain_raw[s]),
      .clamp_i (chain_clamp[s]),
      .raw_o   (chain_raw[s+1]),
      .clamp_o (chain_clamp[s+1])
    );
  end

  // Running sums; the frame leaving the window is the tail cell
  cmav_sum u_raw_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .new_i   (raw_in),
    .old_i   (chain_raw[WindowDepth]),
    .sum_d_o (raw_sum_d),
    .sum_o   (raw_sum_q)
  );

  cmav_sum u_clamp_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .new_i   (clamp_in),
    .old_i   (chain_clamp[WindowDepth]),
    .sum_d_o (clamp_sum_d),
    .sum_o   (clamp_sum_q)
  );

  // Truncated mean is the sum shifted down by the window bits
  always_comb begin
    for (int ch = 0; ch < ChannelCount; ch++) begin
      raw_mean[ch]   = raw_sum_d[ch][SumBits-1:WinBits];
      clamp_mean[ch] = clamp_sum_d[ch][SumBits-1:WinBits];
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_beat_d  = pack_out(raw_mean, clamp_mean);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef NO_ASSERTIONS
  // A taken frame always leaves a result behind it
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted frame produced no result");

  // Input is held back only by a waiting result
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // Shown channel-0 means track the stored running sums
  a_raw_mean_matches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.raw_mean_ch0 == raw_sum_q[0][SumBits-1:WinBits])
    else $error("raw mean out of step with running sum");

  a_clamp_mean_matches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.clamped_mean_ch0 == clamp_sum_q[0][SumBits-1:WinBits])
    else $error("clamped mean out of step with running sum");
`endif

endmodule
